@@ design/ili_pkg.sv @@
// shared types and constants for the indexed list block
package ili_pkg;

  localparam int ILI_CAPACITY = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int LEN_W        = 7;

  typedef enum logic [2:0] {
    MODE_READ     = 3'd0,
    MODE_INS_HEAD = 3'd1,
    MODE_INS_TAIL = 3'd2,
    MODE_INS_AT   = 3'd3,
    MODE_DELETE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

@@ design/ili_cell.sv @@
// one storage cell of the shifting list chain
module ili_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 8
) (
  input  logic                       clk,
  input  ili_pkg::cell_ctrl_t        ctrl,
  input  logic [CMP_W-1:0]           at,
  input  logic [CMP_W-1:0]           rd_pos,
  input  logic signed [ili_pkg::DATA_W-1:0] ins_value,
  input  logic signed [ili_pkg::DATA_W-1:0] left_data,
  input  logic signed [ili_pkg::DATA_W-1:0] right_data,
  output logic signed [ili_pkg::DATA_W-1:0] data,
  output logic signed [ili_pkg::DATA_W-1:0] tap
);
  import ili_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      OP_INSERT: begin
        if (MY_IDX > at) begin
          data_next = left_data;
        end else if (MY_IDX == at) begin
          data_next = ins_value;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= at) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // drives the read bus only when addressed
  assign tap = (MY_IDX == rd_pos) ? data : '0;

endmodule

@@ design/indexed_list_insert_delete.sv @@
// top level of the indexed list with insert and delete
//
// usage: an ordered list of signed 32-bit values held in a row of cells,
// one cell per slot, up to CAPACITY elements
// input channel (in_valid / in_stall) carries mode, position and value;
// a beat is taken when in_valid is high and in_stall is low
// output channel (out_valid / out_stall) carries read_value, found, status
// and length; exactly one result beat per input beat, in order
// result: registered, it shows in the cycle after the input beat; every
// cell compares its own slot number against the position in parallel,
// so inserts and deletes shift the whole row in a single update
// throughput: one beat per cycle while no result is held under out_stall
// stall: while a result waits under out_stall the input is stalled; the
// list itself never changes without an accepted beat
// reset: clears the element count and the output valid; cell contents are
// left as they are and are never read before being written
module indexed_list_insert_delete #(
  parameter int CAPACITY = ili_pkg::ILI_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        mode,
  input  logic [ili_pkg::POS_W-1:0]         position,
  input  logic signed [ili_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ili_pkg::DATA_W-1:0] read_value,
  output logic                              found,
  output logic [1:0]                        status,
  output logic [ili_pkg::LEN_W-1:0]         length
);
  import ili_pkg::*;

  // count must hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width covers both the position field and the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic accept;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] at;

  cell_ctrl_t ctrl;
  status_t    st;
  logic       hit;
  logic signed [DATA_W-1:0] rd;
  logic signed [DATA_W-1:0] bus;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);

  // request decode: status, cell operation, insert point and new count
  always_comb begin
    st         = ST_DONE;
    hit        = 1'b0;
    ctrl.op    = OP_HOLD;
    at         = pos_x;
    count_next = count;
    case (mode)
      MODE_READ: begin
        if (pos_x < cnt_x) begin
          hit = 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AT: begin
        if (mode == MODE_INS_HEAD) begin
          at = '0;
        end else if (mode == MODE_INS_TAIL) begin
          at = cnt_x;
        end
        // range check comes ahead of the full check
        if (at > cnt_x) begin
          st = ST_RANGE;
        end else if (count == CAP_CNT) begin
          st = ST_FULL;
        end else begin
          ctrl.op    = OP_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (pos_x >= cnt_x) begin
          st = ST_RANGE;
        end else begin
          ctrl.op    = OP_DELETE;
          count_next = count - CNT_W'(1);
        end
      end
      default: st = ST_RANGE;
    endcase
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // row of cells: inserts shift toward the tail, deletes toward the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ili_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .at         (at),
      .rd_pos     (pos_x),
      .ins_value  (value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // read bus: only the addressed cell drives a nonzero tap
  always_comb begin
    bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      bus = bus | cell_tap[k];
    end
  end

  always_comb begin
    if (mode == MODE_READ) begin
      rd = hit ? bus : -32'sd1;
    end else begin
      rd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd;
      found      <= hit;
      status     <= st;
      length     <= LEN_W'(count_next);
    end
  end

endmodule
